// File: hdl/tcof_pkg.sv
package tcof_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STAMP_W     = 32;
  localparam int HANDLE_W    = 16;

  // operation codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_ANY  = 2'd1;
  localparam logic [1:0] OP_DEQ0 = 2'd2;
  localparam logic [1:0] OP_DEQ1 = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic                item_class;
    logic [HANDLE_W-1:0] item_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                out_class;
    logic [HANDLE_W-1:0] out_handle;
  } out_item_t;

  // queue to decision logic
  typedef struct packed {
    logic                empty;
    logic                full;
    logic [HANDLE_W-1:0] head_handle;
    logic [STAMP_W-1:0]  head_stamp;
  } queue_stat_t;

  // decision logic to queue
  typedef struct packed {
    logic                push;
    logic                pop;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } queue_ctl_t;

endpackage

// File: hdl/tcof_queue.sv
module tcof_queue
  import tcof_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_ctl_t  ctl,
  output queue_stat_t stat
);

  logic [HANDLE_W-1:0] handles [QUEUE_DEPTH];
  logic [STAMP_W-1:0]  stamps  [QUEUE_DEPTH];
  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    tail;
  logic [CNT_W-1:0]    count;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign stat.empty       = (count == '0);
  assign stat.full        = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.head_handle = handles[head];
  assign stat.head_stamp  = stamps[head];

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      handles[tail] <= ctl.handle;
      stamps[tail]  <= ctl.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        tail  <= next_slot(tail);
        count <= count + CNT_W'(1);
      end else if (ctl.pop) begin
        head  <= next_slot(head);
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (head == tail) == (stat.empty || stat.full))
    else $error("pointers disagree with count");
`endif

endmodule

// File: hdl/tcof_pick.sv
module tcof_pick
  import tcof_pkg::*;
(
  input  logic               fire,
  input  in_item_t           item,
  input  logic [STAMP_W-1:0] stamp_next,
  input  queue_stat_t        stat0,
  input  queue_stat_t        stat1,
  output queue_ctl_t         ctl0,
  output queue_ctl_t         ctl1,
  output logic               stamp_adv,
  output out_item_t          result
);

  logic               push;
  logic               pop;
  logic               sel;
  logic [STAMP_W-1:0] diff;
  logic [1:0]         status;

  assign diff = stat0.head_stamp - stat1.head_stamp;

  always_comb begin
    push   = 1'b0;
    pop    = 1'b0;
    sel    = 1'b0;
    status = ST_OK;
    unique case (item.operation)
      OP_ENQ: begin
        sel = item.item_class;
        if (item.item_class ? stat1.full : stat0.full) begin
          status = ST_FULL;
        end else begin
          push = 1'b1;
        end
      end
      OP_ANY: begin
        priority if (stat0.empty && stat1.empty) begin
          status = ST_EMPTY;
        end else if (stat0.empty) begin
          pop = 1'b1;
          sel = 1'b1;
        end else if (stat1.empty) begin
          pop = 1'b1;
          sel = 1'b0;
        end else begin
          // older head wins, ties go to class 1
          pop = 1'b1;
          sel = !diff[STAMP_W-1];
        end
      end
      OP_DEQ0: begin
        if (stat0.empty) begin
          status = ST_EMPTY;
        end else begin
          pop = 1'b1;
          sel = 1'b0;
        end
      end
      default: begin
        if (stat1.empty) begin
          status = ST_EMPTY;
        end else begin
          pop = 1'b1;
          sel = 1'b1;
        end
      end
    endcase
  end

  assign ctl0.push   = fire && push && !sel;
  assign ctl0.pop    = fire && pop && !sel;
  assign ctl0.handle = item.item_handle;
  assign ctl0.stamp  = stamp_next;
  assign ctl1.push   = fire && push && sel;
  assign ctl1.pop    = fire && pop && sel;
  assign ctl1.handle = item.item_handle;
  assign ctl1.stamp  = stamp_next;

  assign stamp_adv = fire && push;

  assign result.status     = status;
  assign result.out_class  = pop && sel;
  assign result.out_handle = pop ? (sel ? stat1.head_handle : stat0.head_handle)
                                 : '0;

endmodule

// File: hdl/two_class_oldest_first_fifo_top.sv
// an accepted item is captured in the input register (hold), then its result in the result register
// throughput: one item per cycle while out_stall allows; queue state updates in the same cycle
// the decision is made, so back-to-back items see each other's effect
// reset (rst, synchronous, active high) empties both queues, zeroes the arrival
// stamp and clears both valid flags; queue entry storage is not cleared
module two_class_oldest_first_fifo_top
  import tcof_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // input register
  logic      hold_valid;
  in_item_t  hold;

  // global arrival stamp, advanced on every stored enqueue
  logic [STAMP_W-1:0] arrival_stamp;
  logic [STAMP_W-1:0] stamp_next;
  logic               stamp_adv;

  logic        advance;
  logic        fire;
  queue_stat_t stat0;
  queue_stat_t stat1;
  queue_ctl_t  ctl0;
  queue_ctl_t  ctl1;
  out_item_t   result;

  // the result register can take a new item when empty or being drained
  assign advance  = !out_valid || !out_stall;
  // the held item is processed exactly when it moves into the result register
  assign fire     = hold_valid && advance;
  // input register stalls only while its item cannot move on
  assign in_stall = hold_valid && !advance;

  assign stamp_next = arrival_stamp + STAMP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_stamp <= '0;
    end else if (stamp_adv) begin
      arrival_stamp <= stamp_next;
    end
  end

  // class 0 queue
  tcof_queue u_queue0 (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl0),
    .stat (stat0)
  );

  // class 1 queue
  tcof_queue u_queue1 (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl1),
    .stat (stat1)
  );

  // operation decode, full and empty checks, oldest-head choice
  tcof_pick u_pick (
    .fire       (fire),
    .item       (hold),
    .stamp_next (stamp_next),
    .stat0      (stat0),
    .stat1      (stat1),
    .ctl0       (ctl0),
    .ctl1       (ctl1),
    .stamp_adv  (stamp_adv),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule
